### rtl/asps_pkg.sv
// Shared types, constants and functions of the ankle swing-phase stabilizer.
// Holds the channel payloads, the register map, the unit widths and the sine table.
// No dependencies; every other file of the block uses this package.
package asps_pkg;

    // Quarter-wave sine table size, log2 of the number of steps per quarter wave.
    localparam int SINE_TABLE_BITS = 8;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int IDX_W           = SINE_TABLE_BITS + 2;
    localparam int ROM_IDX_W       = SINE_TABLE_BITS + 1;

    // Serial divider: wide enough for the phase index and the rate filter.
    localparam int FILT_DVD_W = 19;
    localparam int DIV_W      = (SINE_TABLE_BITS + 10 > FILT_DVD_W) ?
                                SINE_TABLE_BITS + 10 : FILT_DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int DVS_W      = 9;
    localparam logic [DVS_W-1:0] FILT_DIVISOR = 9'd10;

    // Serial multiplier lanes.
    localparam int MUL_LANES = 4;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int WSUM_W   = 33;
    localparam int SAT_IN_W = MUL_P_W - 15;

    // Register map.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_Y = 3'd5;

    // Swing foot codes.
    localparam logic [1:0] FOOT_LEFT  = 2'd1;
    localparam logic [1:0] FOOT_RIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]         swing_foot;
        logic [7:0]         step_cycles;
        logic [7:0]         current_cycle;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_roll_delta;
        logic signed [15:0] left_pitch_delta;
        logic signed [15:0] right_roll_delta;
        logic signed [15:0] right_pitch_delta;
        logic [15:0]        swing_weight;
    } out_item_t;

    typedef struct packed {
        logic               enable;
        logic [7:0]         double_support_samples;
        logic signed [15:0] gain_p_x;
        logic signed [15:0] gain_p_y;
        logic signed [15:0] gain_d_x;
        logic signed [15:0] gain_d_y;
    } cfg_t;

    typedef logic [15:0] sine_rom_t [0:SINE_N];

    // Q1.15 quarter-wave sine from a Q30 Taylor series up to the x^13 term.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        for (int k = 0; k <= SINE_N; k++) begin
            x    = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + signed'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            q = (64'(sum) + 64'd16384) >> 15;
            if (q > 64'd32768)
            begin
                q = 64'd32768;
            end
            rom[k] = q[15:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic signed [15:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_IN_W'(32767))
        begin
            r = 16'sh7fff;
        end
        else if (v < SAT_IN_W'(-32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [MUL_A_W-1:0] ext_a16(input logic signed [15:0] v);
        return {{(MUL_A_W-16){v[15]}}, v};
    endfunction

endpackage

### rtl/asps_in_if.sv
// Input channel of the stabilizer: one control tick per transfer.
// Uses the payload type from asps_pkg.
interface asps_in_if;
    logic                valid;
    logic                ready;
    asps_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/asps_out_if.sv
// Output channel of the stabilizer: one set of ankle corrections per transfer.
// Uses the payload type from asps_pkg.
interface asps_out_if;
    logic                valid;
    logic                ready;
    asps_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/asps_cfg_if.sv
// Register write channel of the stabilizer: register index and write data.
// Uses the register map widths from asps_pkg.
interface asps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [asps_pkg::CFG_IDX_W-1:0]      index;
    logic [asps_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/asps_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Widths come from asps_pkg.
module asps_sdiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [asps_pkg::DIV_W-1:0]     dividend,
    input  logic [asps_pkg::DVS_W-1:0]     divisor,
    output logic                           busy,
    output logic [asps_pkg::DIV_W-1:0]     quotient
);

    logic                             busy_reg;
    logic                             busy_next;
    logic [asps_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [asps_pkg::DIV_CNT_W-1:0]   cnt_next;
    logic [asps_pkg::DIV_W-1:0]       num_reg;
    logic [asps_pkg::DVS_W-1:0]       dvs_reg;
    logic [asps_pkg::DVS_W-1:0]       rem_reg;
    logic [asps_pkg::DVS_W-1:0]       rem_next;
    logic [asps_pkg::DIV_W-1:0]       quo_reg;
    logic [asps_pkg::DVS_W:0]         trial;
    logic [asps_pkg::DVS_W:0]         diff;
    logic                             ge;
    logic                             last;

    always_comb
    begin
        trial    = {rem_reg, num_reg[asps_pkg::DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[asps_pkg::DVS_W-1:0] : trial[asps_pkg::DVS_W-1:0];
        last     = cnt_reg == asps_pkg::DIV_CNT_W'(asps_pkg::DIV_W - 1);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[asps_pkg::DIV_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[asps_pkg::DIV_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/asps_smul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle, LSB first.
// Widths come from asps_pkg.
module asps_smul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [asps_pkg::MUL_A_W-1:0]   a,
    input  logic signed [asps_pkg::MUL_B_W-1:0]   b,
    output logic                                  busy,
    output logic signed [asps_pkg::MUL_P_W-1:0]   product
);

    logic                               busy_reg;
    logic                               busy_next;
    logic [asps_pkg::MUL_CNT_W-1:0]     cnt_reg;
    logic [asps_pkg::MUL_CNT_W-1:0]     cnt_next;
    logic [asps_pkg::MUL_A_W-1:0]       a_reg;
    logic [asps_pkg::MUL_B_W-1:0]       b_reg;
    logic [asps_pkg::MUL_A_W:0]         hi_reg;
    logic [asps_pkg::MUL_B_W-1:0]       lo_reg;
    logic [asps_pkg::MUL_A_W+1:0]       a_ext;
    logic [asps_pkg::MUL_A_W+1:0]       addend;
    logic [asps_pkg::MUL_A_W+1:0]       sum;
    logic [asps_pkg::MUL_A_W+asps_pkg::MUL_B_W:0] full;
    logic                               last;

    always_comb
    begin
        last  = cnt_reg == asps_pkg::MUL_CNT_W'(asps_pkg::MUL_B_W - 1);
        a_ext = {{2{a_reg[asps_pkg::MUL_A_W-1]}}, a_reg};
        // The top multiplier bit carries negative weight.
        if (!b_reg[0])
        begin
            addend = '0;
        end
        else if (last)
        begin
            addend = -a_ext;
        end
        else
        begin
            addend = a_ext;
        end
        sum = {hi_reg[asps_pkg::MUL_A_W], hi_reg} + addend;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        full    = {hi_reg, lo_reg};
        product = full[asps_pkg::MUL_P_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg  <= {1'b0, b_reg[asps_pkg::MUL_B_W-1:1]};
            hi_reg <= sum[asps_pkg::MUL_A_W+1:1];
            lo_reg <= {sum[0], lo_reg[asps_pkg::MUL_B_W-1:1]};
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/asps_cfg_regs.sv
// Configuration register file of the stabilizer, written over the register channel.
// Uses the register map and cfg_t from asps_pkg and the asps_cfg_if interface.
module asps_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    asps_cfg_if.sink        cfg,
    output asps_pkg::cfg_t  regs
);

    asps_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else if (cfg.valid)
        begin
            // Writes to indexes beyond the register list are dropped.
            case (cfg.index)
                asps_pkg::CFG_ENABLE:   regs_reg.enable                 <= cfg.data[0];
                asps_pkg::CFG_DS:       regs_reg.double_support_samples <= cfg.data[7:0];
                asps_pkg::CFG_GAIN_P_X: regs_reg.gain_p_x               <= cfg.data;
                asps_pkg::CFG_GAIN_P_Y: regs_reg.gain_p_y               <= cfg.data;
                asps_pkg::CFG_GAIN_D_X: regs_reg.gain_d_x               <= cfg.data;
                asps_pkg::CFG_GAIN_D_Y: regs_reg.gain_d_y               <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

### rtl/ankle_swing_phase_stabilizer.sv
// Top level of the ankle swing-phase stabilizer: sequencer, rate filter state and
// output register. Uses asps_pkg, the three channel interfaces, asps_cfg_regs,
// asps_sdiv and asps_smul.

// One control tick is worked on at a time. An enabled tick goes through one pass of three
// bit-serial dividers (phase index and the two rate filters) that also hides the
// proportional products, then two passes of four bit-serial 34x17 multiplier lanes, one
// for the derivative terms and the squared sine, one for the weighted corrections. A
// disabled tick goes straight from idle to the done state. The result waits in an output
// register, so the next tick is taken while the previous result is still pending.
module ankle_swing_phase_stabilizer (
    input  logic        clk,
    input  logic        rst_n,
    asps_in_if.sink     tick,
    asps_out_if.source  result,
    asps_cfg_if.sink    cfg
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_S1   = 3'd1;
    localparam logic [2:0] ST_W1   = 3'd2;
    localparam logic [2:0] ST_S2   = 3'd3;
    localparam logic [2:0] ST_W2   = 3'd4;
    localparam logic [2:0] ST_S3   = 3'd5;
    localparam logic [2:0] ST_W3   = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam int SUP_RND = 1 << 22;
    localparam int SW_RND  = 1 << 14;

    asps_pkg::cfg_t         regs;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    asps_pkg::in_item_t     item_reg;
    logic signed [15:0]     srx_reg;
    logic signed [15:0]     sry_reg;
    logic signed [15:0]     srx_next;
    logic signed [15:0]     sry_next;
    logic                   phase_ok_reg;
    logic                   fneg_x_reg;
    logic                   fneg_y_reg;
    logic signed [31:0]     ppx_reg;
    logic signed [31:0]     ppy_reg;
    logic [15:0]            s_reg;
    logic [15:0]            z_reg;
    logic [15:0]            z_next;
    logic signed [asps_pkg::WSUM_W-1:0] wx_reg;
    logic signed [asps_pkg::WSUM_W-1:0] wy_reg;
    asps_pkg::out_item_t    res_reg;
    asps_pkg::out_item_t    res_next;
    asps_pkg::out_item_t    out_reg;
    logic                   out_valid_reg;

    logic                   tick_xfer;
    logic                   out_load;
    logic                   all_idle;

    logic                   div_start;
    logic [asps_pkg::DIV_W-1:0] div_dvd [3];
    logic [asps_pkg::DVS_W-1:0] div_dvs [3];
    logic [asps_pkg::DIV_W-1:0] div_quo [3];
    logic [2:0]             div_busy;

    logic                   mul_start;
    logic signed [asps_pkg::MUL_A_W-1:0] mul_a [asps_pkg::MUL_LANES];
    logic signed [asps_pkg::MUL_B_W-1:0] mul_b [asps_pkg::MUL_LANES];
    logic signed [asps_pkg::MUL_P_W-1:0] mul_p [asps_pkg::MUL_LANES];
    logic [asps_pkg::MUL_LANES-1:0] mul_busy;

    // Phase index setup.
    logic [8:0]             c2;
    logic [7:0]             ss;
    logic [8:0]             num;
    logic                   phase_ok;

    // Rate filter setup and finish.
    logic [18:0]            fsum_x;
    logic [18:0]            fsum_y;
    logic [18:0]            fmag_x;
    logic [18:0]            fmag_y;
    logic [18:0]            fdvd_x;
    logic [18:0]            fdvd_y;
    logic [16:0]            fq_x;
    logic [16:0]            fq_y;
    logic [16:0]            fqn_x;
    logic [16:0]            fqn_y;

    // Sine table lookup.
    logic [asps_pkg::IDX_W-1:0]     idx_cl;
    logic [asps_pkg::IDX_W-1:0]     idx_f;
    logic [asps_pkg::ROM_IDX_W-1:0] rom_idx;

    // Weight and correction finish.
    logic [31:0]            zsum;
    logic signed [31:0]     dpx;
    logic signed [31:0]     dpy;
    logic signed [asps_pkg::MUL_P_W-1:0] rnd_sup_r;
    logic signed [asps_pkg::MUL_P_W-1:0] rnd_sup_p;
    logic signed [asps_pkg::MUL_P_W-1:0] rnd_sw_r;
    logic signed [asps_pkg::MUL_P_W-1:0] rnd_sw_p;
    logic signed [15:0]     sup_r;
    logic signed [15:0]     sup_p;
    logic signed [15:0]     sw_r;
    logic signed [15:0]     sw_p;

    asps_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        asps_sdiv u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_dvd[g]),
            .divisor  (div_dvs[g]),
            .busy     (div_busy[g]),
            .quotient (div_quo[g])
        );
    end

    for (genvar g = 0; g < asps_pkg::MUL_LANES; g++)
    begin : g_mul
        asps_smul u_mul (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (mul_start),
            .a       (mul_a[g]),
            .b       (mul_b[g]),
            .busy    (mul_busy[g]),
            .product (mul_p[g])
        );
    end

    assign tick.ready   = (state_reg == ST_IDLE);
    assign tick_xfer    = tick.valid && (state_reg == ST_IDLE);
    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign all_idle     = !(|mul_busy) && !(|div_busy);
    assign div_start    = (state_reg == ST_S1);
    assign mul_start    = (state_reg == ST_S1) || (state_reg == ST_S2) ||
                          (state_reg == ST_S3);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Single support test and the phase index division t * 2N, rounded half up.
    always_comb
    begin
        c2       = {item_reg.current_cycle, 1'b0};
        ss       = item_reg.step_cycles - regs.double_support_samples;
        num      = c2 - {1'b0, regs.double_support_samples};
        phase_ok = (item_reg.step_cycles > regs.double_support_samples) &&
                   (c2 > {1'b0, regs.double_support_samples}) &&
                   (({1'b0, c2} + {2'b00, regs.double_support_samples}) <=
                    {1'b0, item_reg.step_cycles, 1'b0});
    end

    // The filter divides 4*old + rate by five with ties away from zero.
    always_comb
    begin
        fsum_x = {srx_reg[15], srx_reg, 2'b00} +
                 {{3{item_reg.rate_x[15]}}, item_reg.rate_x};
        fsum_y = {sry_reg[15], sry_reg, 2'b00} +
                 {{3{item_reg.rate_y[15]}}, item_reg.rate_y};
        fmag_x = fsum_x[18] ? -fsum_x : fsum_x;
        fmag_y = fsum_y[18] ? -fsum_y : fsum_y;
        fdvd_x = {fmag_x[17:0], 1'b0} + 19'd5;
        fdvd_y = {fmag_y[17:0], 1'b0} + 19'd5;

        div_dvd[0] = (asps_pkg::DIV_W'(num) << (asps_pkg::SINE_TABLE_BITS + 1)) +
                     asps_pkg::DIV_W'(ss);
        div_dvs[0] = {ss, 1'b0};
        div_dvd[1] = asps_pkg::DIV_W'(fdvd_x);
        div_dvs[1] = asps_pkg::FILT_DIVISOR;
        div_dvd[2] = asps_pkg::DIV_W'(fdvd_y);
        div_dvs[2] = asps_pkg::FILT_DIVISOR;

        fq_x     = div_quo[1][16:0];
        fq_y     = div_quo[2][16:0];
        fqn_x    = -fq_x;
        fqn_y    = -fq_y;
        srx_next = fneg_x_reg ? fqn_x[15:0] : fq_x[15:0];
        sry_next = fneg_y_reg ? fqn_y[15:0] : fq_y[15:0];
    end

    // Clamp the index to a half wave, then fold it onto the quarter-wave table.
    always_comb
    begin
        idx_cl = (div_quo[0] > asps_pkg::DIV_W'(2 * asps_pkg::SINE_N)) ?
                 asps_pkg::IDX_W'(2 * asps_pkg::SINE_N) :
                 div_quo[0][asps_pkg::IDX_W-1:0];
        idx_f  = (idx_cl > asps_pkg::IDX_W'(asps_pkg::SINE_N)) ?
                 asps_pkg::IDX_W'(2 * asps_pkg::SINE_N) - idx_cl : idx_cl;
        rom_idx = idx_f[asps_pkg::ROM_IDX_W-1:0];
    end

    // Multiplier lane operands for each pass.
    always_comb
    begin
        for (int i = 0; i < asps_pkg::MUL_LANES; i++)
        begin
            mul_a[i] = '0;
            mul_b[i] = '0;
        end
        case (state_reg)
            ST_S1:
            begin
                mul_a[0] = asps_pkg::ext_a16(regs.gain_p_x);
                mul_b[0] = {item_reg.tilt_x[15], item_reg.tilt_x};
                mul_a[1] = asps_pkg::ext_a16(regs.gain_p_y);
                mul_b[1] = {item_reg.tilt_y[15], item_reg.tilt_y};
            end
            ST_S2:
            begin
                mul_a[0] = asps_pkg::ext_a16(regs.gain_d_x);
                mul_b[0] = {srx_reg[15], srx_reg};
                mul_a[1] = asps_pkg::ext_a16(regs.gain_d_y);
                mul_b[1] = {sry_reg[15], sry_reg};
                mul_a[2] = {{(asps_pkg::MUL_A_W-16){1'b0}}, s_reg};
                mul_b[2] = {1'b0, s_reg};
            end
            ST_S3:
            begin
                mul_a[0] = {{(asps_pkg::MUL_A_W-asps_pkg::WSUM_W){wx_reg[asps_pkg::WSUM_W-1]}},
                            wx_reg};
                mul_b[0] = {1'b0, z_reg};
                mul_a[1] = {{(asps_pkg::MUL_A_W-asps_pkg::WSUM_W){wy_reg[asps_pkg::WSUM_W-1]}},
                            wy_reg};
                mul_b[1] = {1'b0, z_reg};
                // The swing ankle works against the tilt.
                mul_a[2] = -asps_pkg::ext_a16(item_reg.tilt_x);
                mul_b[2] = {1'b0, z_reg};
                mul_a[3] = -asps_pkg::ext_a16(item_reg.tilt_y);
                mul_b[3] = {1'b0, z_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Weight, gain sums and the final rounded corrections.
    always_comb
    begin
        zsum   = mul_p[2][31:0] + 32'd16384;
        z_next = phase_ok_reg ? zsum[30:15] : 16'd0;
        dpx    = mul_p[0][31:0];
        dpy    = mul_p[1][31:0];

        rnd_sup_r = mul_p[0] + asps_pkg::MUL_P_W'(SUP_RND);
        rnd_sup_p = mul_p[1] + asps_pkg::MUL_P_W'(SUP_RND);
        rnd_sw_r  = mul_p[2] + asps_pkg::MUL_P_W'(SW_RND);
        rnd_sw_p  = mul_p[3] + asps_pkg::MUL_P_W'(SW_RND);
        sup_r = asps_pkg::sat16({{8{rnd_sup_r[asps_pkg::MUL_P_W-1]}},
                                 rnd_sup_r[asps_pkg::MUL_P_W-1:23]});
        sup_p = asps_pkg::sat16({{8{rnd_sup_p[asps_pkg::MUL_P_W-1]}},
                                 rnd_sup_p[asps_pkg::MUL_P_W-1:23]});
        sw_r  = asps_pkg::sat16(rnd_sw_r[asps_pkg::MUL_P_W-1:15]);
        sw_p  = asps_pkg::sat16(rnd_sw_p[asps_pkg::MUL_P_W-1:15]);

        res_next              = '0;
        res_next.swing_weight = z_reg;
        case (item_reg.swing_foot)
            asps_pkg::FOOT_LEFT:
            begin
                res_next.left_roll_delta   = sw_r;
                res_next.left_pitch_delta  = sw_p;
                res_next.right_roll_delta  = sup_r;
                res_next.right_pitch_delta = sup_p;
            end
            asps_pkg::FOOT_RIGHT:
            begin
                res_next.right_roll_delta  = sw_r;
                res_next.right_pitch_delta = sw_p;
                res_next.left_roll_delta   = sup_r;
                res_next.left_pitch_delta  = sup_p;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = regs.enable ? ST_S1 : ST_DONE;
                end
            end
            ST_S1: state_next = ST_W1;
            ST_W1:
            begin
                if (all_idle)
                begin
                    state_next = ST_S2;
                end
            end
            ST_S2: state_next = ST_W2;
            ST_W2:
            begin
                if (all_idle)
                begin
                    state_next = ST_S3;
                end
            end
            ST_S3: state_next = ST_W3;
            ST_W3:
            begin
                if (all_idle)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            srx_reg       <= '0;
            sry_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // The filter only advances on enabled ticks.
            if ((state_reg == ST_W1) && all_idle)
            begin
                srx_reg <= srx_next;
                sry_reg <= sry_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            item_reg <= tick.data;
            if (!regs.enable)
            begin
                res_reg <= '0;
            end
        end
        if (state_reg == ST_S1)
        begin
            phase_ok_reg <= phase_ok;
            fneg_x_reg   <= fsum_x[18];
            fneg_y_reg   <= fsum_y[18];
        end
        if ((state_reg == ST_W1) && all_idle)
        begin
            s_reg   <= asps_pkg::SINE_ROM[rom_idx];
            ppx_reg <= mul_p[0][31:0];
            ppy_reg <= mul_p[1][31:0];
        end
        if ((state_reg == ST_W2) && all_idle)
        begin
            z_reg  <= z_next;
            wx_reg <= {ppx_reg[31], ppx_reg} + {dpx[31], dpx};
            wy_reg <= {ppy_reg[31], ppy_reg} + {dpy[31], dpy};
        end
        if ((state_reg == ST_W3) && all_idle)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

### tb/tb_ankle_swing_phase_stabilizer.sv
// Self-checking testbench for the ankle swing-phase stabilizer top level.
// Depends on asps_pkg, the tick/result/config channel interfaces and the RTL top.
// Each tick is predicted at its input transfer and checked in order at its result.
module tb_ankle_swing_phase_stabilizer;

    localparam logic [1:0] FOOT_NONE  = 2'd0;
    localparam logic [1:0] FOOT_SPARE = 2'd3;
    localparam logic [asps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [asps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam logic signed [15:0] Q_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;
    localparam int unsigned RANDOM_TICKS   = 300;
    localparam int unsigned IDLE_SETTLE    = 4;
    localparam int unsigned DRAIN_LIMIT    = 50000;
    localparam int unsigned DRAIN_SETTLE   = 80;
    localparam int unsigned HOLD_OFF_LEN   = 600;
    localparam int unsigned TIMEOUT_UNITS  = 8000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    asps_in_if  tick_ch ();
    asps_out_if result_ch ();
    asps_cfg_if cfg_ch ();

    ankle_swing_phase_stabilizer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the registers and the filtered gyro rates.
    logic               en_q = 1'b0;
    logic [7:0]         ds_q = '0;
    logic signed [15:0] kp_x = '0;
    logic signed [15:0] kp_y = '0;
    logic signed [15:0] kd_x = '0;
    logic signed [15:0] kd_y = '0;
    logic signed [15:0] filt_x = '0;
    logic signed [15:0] filt_y = '0;
    logic [15:0]        sine_q15 [0:asps_pkg::SINE_N];

    asps_pkg::out_item_t corrections_due [$];
    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned fault_count = 0;
    int unsigned hold_off_len = 0;
    bit          no_gaps = 1'b0;

    // Q30 Taylor series of sin up to x^13, rounded to Q1.15.
    function automatic logic [15:0] sine_entry(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        x    = (64'd1686629713 * 64'(k)) / asps_pkg::SINE_N;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32768)
            q = 64'd32768;
        return q[15:0];
    endfunction

    initial
    begin
        for (int k = 0; k <= asps_pkg::SINE_N; k++)
            sine_q15[k] = sine_entry(k);
    end

    function automatic logic [15:0] phase_weight_q15(logic [7:0] steps, logic [7:0] cyc);
        int              ds;
        int              ss;
        int              c2;
        longint unsigned num;
        longint unsigned den;
        longint unsigned idx;
        longint unsigned s;
        ds = int'(ds_q);
        ss = int'(steps) - ds;
        c2 = 2 * int'(cyc);
        if (ss <= 0 || c2 <= ds || c2 > ds + 2 * ss)
            return 16'd0;
        num = c2 - ds;
        den = 2 * ss;
        idx = (num * 4 * asps_pkg::SINE_N + den) / (2 * den);
        if (idx > 2 * asps_pkg::SINE_N)
            idx = 2 * asps_pkg::SINE_N;
        if (idx > asps_pkg::SINE_N)
            idx = 2 * asps_pkg::SINE_N - idx;
        s = sine_q15[idx];
        return 16'((s * s + 64'd16384) >> 15);
    endfunction

    // Divide by five with ties away from zero.
    function automatic logic signed [15:0] lowpass(logic signed [15:0] old,
                                                   logic signed [15:0] r);
        int s;
        int m;
        int q;
        s = 4 * int'(old) + int'(r);
        m = (s < 0) ? -s : s;
        q = (m * 2 + 5) / 10;
        return (s < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return Q_MAX;
        if (v < -32768)
            return Q_MIN;
        return v[15:0];
    endfunction

    function automatic asps_pkg::out_item_t predict_corrections(asps_pkg::in_item_t it);
        asps_pkg::out_item_t o;
        longint             wx;
        longint             wy;
        longint             z;
        logic signed [15:0] sup_r;
        logic signed [15:0] sup_p;
        logic signed [15:0] sw_r;
        logic signed [15:0] sw_p;
        o = '0;
        if (!en_q)
            return o;
        z = longint'(phase_weight_q15(it.step_cycles, it.current_cycle));
        o.swing_weight = z[15:0];
        filt_x = lowpass(filt_x, it.rate_x);
        filt_y = lowpass(filt_y, it.rate_y);
        if (it.swing_foot == asps_pkg::FOOT_LEFT || it.swing_foot == asps_pkg::FOOT_RIGHT)
        begin
            wx = longint'(kp_x) * longint'(it.tilt_x) + longint'(kd_x) * longint'(filt_x);
            wy = longint'(kp_y) * longint'(it.tilt_y) + longint'(kd_y) * longint'(filt_y);
            sup_r = clamp16(rnd_shift(wx * z, 23));
            sup_p = clamp16(rnd_shift(wy * z, 23));
            sw_r  = clamp16(rnd_shift(-longint'(it.tilt_x) * z, 15));
            sw_p  = clamp16(rnd_shift(-longint'(it.tilt_y) * z, 15));
            if (it.swing_foot == asps_pkg::FOOT_LEFT)
            begin
                o.left_roll_delta   = sw_r;
                o.left_pitch_delta  = sw_p;
                o.right_roll_delta  = sup_r;
                o.right_pitch_delta = sup_p;
            end
            else
            begin
                o.right_roll_delta  = sw_r;
                o.right_pitch_delta = sw_p;
                o.left_roll_delta   = sup_r;
                o.left_pitch_delta  = sup_p;
            end
        end
        return o;
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(12, 60);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic signed [15:0] rand_q412();
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 65535)) - 32768;
            1:       v = int'($urandom_range(0, 4096)) - 2048;
            2:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 16384)) - 8192;
        endcase
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] rand_gain();
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 65535)) - 32768;
            1:       v = int'($urandom_range(0, 1024)) - 512;
            2:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 128)) - 64;
        endcase
        return v[15:0];
    endfunction

    function automatic asps_pkg::in_item_t make_tick(logic [1:0] foot, logic [7:0] steps,
                                                     logic [7:0] cyc, logic signed [15:0] tx,
                                                     logic signed [15:0] ty,
                                                     logic signed [15:0] rx,
                                                     logic signed [15:0] ry);
        asps_pkg::in_item_t it;
        it.swing_foot    = foot;
        it.step_cycles   = steps;
        it.current_cycle = cyc;
        it.tilt_x        = tx;
        it.tilt_y        = ty;
        it.rate_x        = rx;
        it.rate_y        = ry;
        return it;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    // Valid stays high after a transfer; it drops only ahead of a gap or an idle wait.
    task automatic send_tick(input asps_pkg::in_item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= it;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        corrections_due.push_back(predict_corrections(it));
        ticks_sent++;
    endtask

    task automatic settle_idle();
        tick_ch.valid <= 1'b0;
        while (corrections_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [asps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            asps_pkg::CFG_ENABLE:   en_q = val[0];
            asps_pkg::CFG_DS:       ds_q = val[7:0];
            asps_pkg::CFG_GAIN_P_X: kp_x = val;
            asps_pkg::CFG_GAIN_P_Y: kp_y = val;
            asps_pkg::CFG_GAIN_D_X: kd_x = val;
            asps_pkg::CFG_GAIN_D_Y: kd_y = val;
            default:                ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input bit en, input logic [7:0] ds,
                              input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic signed [15:0] dx, input logic signed [15:0] dy);
        settle_idle();
        write_reg(asps_pkg::CFG_ENABLE, 16'(en));
        write_reg(asps_pkg::CFG_DS, 16'(ds));
        write_reg(asps_pkg::CFG_GAIN_P_X, px);
        write_reg(asps_pkg::CFG_GAIN_P_Y, py);
        write_reg(asps_pkg::CFG_GAIN_D_X, dx);
        write_reg(asps_pkg::CFG_GAIN_D_Y, dy);
    endtask

    task automatic send_step(input logic [1:0] foot, input int steps, input int stride);
        for (int c = 0; c < steps; c += stride)
            send_tick(make_tick(foot, 8'(steps), 8'(c), rand_q412(), rand_q412(),
                                rand_q412(), rand_q412()));
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_tick(make_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                                rand_q412(), rand_q412(), rand_q412(), rand_q412()));
    endtask

    // After reset the block is disabled, so every result is all zero.
    task automatic test_reset_state();
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd60, 8'd30, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_tick(make_tick(asps_pkg::FOOT_RIGHT, 8'd60, 8'd30, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    endtask

    task automatic test_directed_cases();
        set_config(1'b1, 8'd20, 16'sh0180, -16'sh0100, 16'sh0040, Q_MAX);
        // Peak of the swing phase with extreme tilts and rates on both feet, then with no valid swing foot.
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd60, 8'd30, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_tick(make_tick(asps_pkg::FOOT_RIGHT, 8'd60, 8'd30, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_tick(make_tick(FOOT_NONE, 8'd60, 8'd30, Q_MAX, Q_MAX, 16'sd4096, 16'sd4096));
        send_tick(make_tick(FOOT_SPARE, 8'd60, 8'd30, Q_MIN, Q_MIN, -16'sd4096, 16'sd0));
        // Edges of single support.
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd60, 8'd10, 16'sd4096, 16'sd4096,
                            16'sd0, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd60, 8'd11, 16'sd4096, -16'sd4096,
                            16'sd100, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd60, 8'd50, 16'sd4096, 16'sd4096,
                            16'sd0, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd60, 8'd51, 16'sd4096, 16'sd4096,
                            16'sd0, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_RIGHT, 8'd255, 8'd255, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        // Step no longer than double support, then two ticks inside single support.
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd20, 8'd15, Q_MAX, Q_MAX, 16'sd0, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_RIGHT, 8'd5, 8'd3, Q_MIN, Q_MIN, 16'sd0, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd0, 8'd0, Q_MAX, Q_MIN, 16'sd0, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd60, 8'd20, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0));
        send_tick(make_tick(asps_pkg::FOOT_RIGHT, 8'd60, 8'd40, 16'sd300, -16'sd300,
                            16'sd7, -16'sd7));
        set_config(1'b1, 8'd0, Q_MAX, Q_MIN, Q_MIN, Q_MAX);
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd1, 8'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd1, 8'd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_tick(make_tick(asps_pkg::FOOT_RIGHT, 8'd2, 8'd1, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        // While disabled the filtered rates must hold their value.
        set_config(1'b0, 8'd0, Q_MAX, Q_MIN, Q_MIN, Q_MAX);
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd2, 8'd1, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
        send_tick(make_tick(asps_pkg::FOOT_RIGHT, 8'd2, 8'd1, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
        set_config(1'b1, 8'd0, Q_MAX, Q_MIN, Q_MIN, Q_MAX);
        send_tick(make_tick(asps_pkg::FOOT_LEFT, 8'd2, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    endtask

    task automatic test_ignored_index();
        set_config(1'b1, 8'd10, 16'sh0200, 16'sh0080, -16'sh0020, 16'sh0100);
        write_reg(CFG_IDX_SPARE_LO, 16'h8001);
        write_reg(CFG_IDX_SPARE_HI, 16'h0000);
        send_step(asps_pkg::FOOT_LEFT, 30, 1);
    endtask

    task automatic test_config_extremes();
        set_config(1'b1, 8'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_step(asps_pkg::FOOT_RIGHT, 24, 1);
        set_config(1'b1, 8'd255, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_step(asps_pkg::FOOT_LEFT, 255, 32);
        set_config(1'b1, 8'd1, Q_MIN, Q_MAX, 16'sd0, Q_MIN);
        send_step(asps_pkg::FOOT_LEFT, 16, 1);
    endtask

    // The receiver holds off while ticks keep coming, so the block fills and stalls.
    task automatic test_backpressure();
        set_config(1'b1, 8'd6, 16'sh0100, 16'sh0100, 16'sh0080, 16'sh0080);
        no_gaps = 1'b1;
        hold_off_len = HOLD_OFF_LEN;
        send_step(asps_pkg::FOOT_RIGHT, 16, 1);
        settle_idle();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_walk();
        int unsigned start;
        int unsigned phase;
        logic [7:0]  ds;
        logic [1:0]  foot;
        int          steps;
        start = ticks_sent;
        phase = 0;
        foot  = asps_pkg::FOOT_LEFT;
        while (ticks_sent - start < RANDOM_TICKS)
        begin
            case ($urandom_range(0, 7))
                0:       ds = 8'd0;
                1:       ds = 8'd255;
                2, 3:    ds = 8'($urandom_range(1, 12));
                default: ds = 8'($urandom_range(0, 48));
            endcase
            set_config($urandom_range(0, 5) != 0, ds, rand_gain(), rand_gain(),
                       rand_gain(), rand_gain());
            no_gaps = (phase % 4 == 3);
            repeat (4)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise(6);
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        steps = $urandom_range(0, ds);
                    else
                        steps = int'(ds) + $urandom_range(2, 40);
                    if (steps > 255)
                        steps = 255;
                    send_step(($urandom_range(0, 7) == 0) ? FOOT_NONE : foot, steps,
                              1 + steps / 48);
                    foot = (foot == asps_pkg::FOOT_LEFT) ? asps_pkg::FOOT_RIGHT :
                           asps_pkg::FOOT_LEFT;
                end
            end
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin : ready_driver
        int unsigned n;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_len != 0)
            begin
                n = hold_off_len;
                hold_off_len = 0;
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n == 0)
                begin
                    result_ch.ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    result_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_checker
        asps_pkg::out_item_t want;
        asps_pkg::out_item_t got;
        bit                  bad;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got = result_ch.data;
            if (corrections_due.size() == 0)
                note_fault($sformatf("result %0d arrived with nothing expected", results_seen));
            else
            begin
                want = corrections_due.pop_front();
                bad = (got.left_roll_delta !== want.left_roll_delta)
                    || (got.left_pitch_delta !== want.left_pitch_delta)
                    || (got.right_roll_delta !== want.right_roll_delta)
                    || (got.right_pitch_delta !== want.right_pitch_delta)
                    || (got.swing_weight !== want.swing_weight);
                if (bad)
                    note_fault($sformatf(
                        "result %0d: expected %0d %0d %0d %0d w=%0d, got %0d %0d %0d %0d w=%0d",
                        results_seen, want.left_roll_delta, want.left_pitch_delta,
                        want.right_roll_delta, want.right_pitch_delta, want.swing_weight,
                        got.left_roll_delta, got.left_pitch_delta, got.right_roll_delta,
                        got.right_pitch_delta, got.swing_weight));
            end
            results_seen++;
        end
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : main_sequence
        int unsigned waited;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_cases();
        test_ignored_index();
        test_config_extremes();
        test_backpressure();
        test_random_walk();

        tick_ch.valid <= 1'b0;
        waited = 0;
        while (corrections_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_SETTLE) @(posedge clk);
        if (corrections_due.size() != 0)
            note_fault($sformatf("%0d expected results never arrived",
                                 corrections_due.size()));
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
